@@ rtl/core/lsmt_pkg.sv @@
// shared types, mode codes and timing defaults for the lcd scanline mode timer
package lsmt_pkg;

  // default line timing
  localparam int LINE_CYCLES_DEF   = 456;
  localparam int SCAN_CYCLES_DEF   = 80;
  localparam int XFER_CYCLES_DEF   = 172;
  localparam int VISIBLE_LINES_DEF = 144;
  localparam int LAST_LINE_DEF     = 153;

  // mode codes as seen in the status register
  localparam logic [1:0] MODE_HBLANK = 2'd0;
  localparam logic [1:0] MODE_VBLANK = 2'd1;
  localparam logic [1:0] MODE_SCAN   = 2'd2;
  localparam logic [1:0] MODE_XFER   = 2'd3;

  // one tick request
  typedef struct packed {
    logic [5:0] tick_cycles;
    logic       lcd_enable;
    logic       hblank_irq_en;
    logic       vblank_irq_en;
    logic       oam_irq_en;
    logic       match_irq_en;
    logic [7:0] compare_line;
  } lsmt_in_t;

  // one result
  typedef struct packed {
    logic [7:0] line_now;
    logic [1:0] mode_now;
    logic       line_match;
    logic       status_irq;
    logic       vblank_irq;
    logic       line_start;
    logic       frame_wrap;
  } lsmt_out_t;

endpackage

@@ rtl/core/lsmt_core.sv @@
// line countdown, line and mode state with the per-tick update logic
module lsmt_core
  import lsmt_pkg::*;
#(
  parameter int LINE_CYCLES   = LINE_CYCLES_DEF,
  parameter int SCAN_CYCLES   = SCAN_CYCLES_DEF,
  parameter int XFER_CYCLES   = XFER_CYCLES_DEF,
  parameter int VISIBLE_LINES = VISIBLE_LINES_DEF,
  parameter int LAST_LINE     = LAST_LINE_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step_en,
  input  lsmt_in_t  req,
  output lsmt_out_t res
);

  localparam int CNT_W      = $clog2(LINE_CYCLES + 1);
  localparam int SCAN_BOUND = LINE_CYCLES - SCAN_CYCLES;
  localparam int XFER_BOUND = SCAN_BOUND - XFER_CYCLES;
  // countdown never drops below one, so a bound at or under zero always holds
  localparam logic [CNT_W-1:0] SCAN_CMP = CNT_W'((SCAN_BOUND > 0) ? SCAN_BOUND : 0);
  localparam logic [CNT_W-1:0] XFER_CMP = CNT_W'((XFER_BOUND > 0) ? XFER_BOUND : 0);
  localparam logic [CNT_W-1:0] CNT_RST  = CNT_W'(LINE_CYCLES);
  localparam logic [8:0]       VIS_L    = 9'(VISIBLE_LINES);
  localparam logic [8:0]       LAST_L   = 9'(LAST_LINE);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [7:0]       line_r, line_nxt;
  logic [1:0]       pmode_r, pmode_nxt;
  logic             match_r, match_nxt;

  logic [1:0]       mode;
  logic             mode_req;
  logic             sirq;
  logic signed [CNT_W:0] diff;
  logic             expired;
  logic [8:0]       next_line;

  // mode decode from line and countdown
  always_comb begin
    mode     = MODE_HBLANK;
    mode_req = 1'b0;
    if (line_r >= 8'(VISIBLE_LINES)) begin
      mode     = MODE_VBLANK;
      mode_req = req.vblank_irq_en;
    end else if (cnt_r >= SCAN_CMP) begin
      mode     = MODE_SCAN;
      mode_req = req.oam_irq_en;
    end else if (cnt_r >= XFER_CMP) begin
      mode     = MODE_XFER;
    end else begin
      mode_req = req.hblank_irq_en;
    end
  end

  // countdown and line advance
  assign diff      = $signed({1'b0, cnt_r}) - $signed({{(CNT_W - 5){1'b0}}, req.tick_cycles});
  assign expired   = diff[CNT_W] || (diff == '0);
  assign next_line = {1'b0, line_r} + 9'd1;

  always_comb begin
    cnt_nxt   = cnt_r;
    line_nxt  = line_r;
    pmode_nxt = pmode_r;
    match_nxt = match_r;
    sirq      = 1'b0;
    res       = '0;
    if (!req.lcd_enable) begin
      cnt_nxt        = CNT_RST;
      line_nxt       = '0;
      pmode_nxt      = MODE_HBLANK;
      res.line_match = match_r;
    end else begin
      match_nxt = (line_r == req.compare_line);
      sirq      = (mode_req && (mode != pmode_r)) || (match_nxt && req.match_irq_en);
      pmode_nxt = mode;
      cnt_nxt   = diff[CNT_W-1:0];
      if (expired) begin
        cnt_nxt  = CNT_RST;
        line_nxt = next_line[7:0];
        priority if (next_line == VIS_L) begin
          res.vblank_irq = 1'b1;
        end else if (next_line > LAST_L) begin
          line_nxt       = '0;
          res.frame_wrap = 1'b1;
        end else if (next_line < VIS_L) begin
          res.line_start = 1'b1;
        end
      end
      res.line_now   = line_nxt;
      res.mode_now   = mode;
      res.line_match = match_nxt;
      res.status_irq = sirq;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= CNT_RST;
      line_r  <= '0;
      pmode_r <= MODE_HBLANK;
      match_r <= 1'b0;
    end else if (step_en) begin
      cnt_r   <= cnt_nxt;
      line_r  <= line_nxt;
      pmode_r <= pmode_nxt;
      match_r <= match_nxt;
    end
  end

endmodule

@@ rtl/core/lcd_scanline_mode_timer_top.sv @@
// Top level of the lcd scanline mode timer: input register, update logic, result register.
// Path: a request is held in the input register, and as it leaves, the update logic writes
// its result into the result register.
// Throughput: one request per cycle while out_stall is low; the line state is updated as a
// request leaves the input register, so the following request sees it there.
// Reset (synchronous, rst_n low): both valids cleared, countdown to a full line, line,
// previous mode and match flag to zero.
module lcd_scanline_mode_timer_top
  import lsmt_pkg::*;
#(
  parameter int LINE_CYCLES   = LINE_CYCLES_DEF,
  parameter int SCAN_CYCLES   = SCAN_CYCLES_DEF,
  parameter int XFER_CYCLES   = XFER_CYCLES_DEF,
  parameter int VISIBLE_LINES = VISIBLE_LINES_DEF,
  parameter int LAST_LINE     = LAST_LINE_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  lsmt_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output lsmt_out_t out_data
);

  logic      in_valid_r;
  lsmt_in_t  in_data_r;
  logic      out_valid_r;
  lsmt_out_t out_data_r;
  lsmt_out_t res;
  logic      out_adv;
  logic      step_en;
  logic      in_load;

  // pipeline handshake
  assign out_adv  = !out_valid_r || !out_stall;
  assign step_en  = in_valid_r && out_adv;
  assign in_stall = in_valid_r && !out_adv;
  assign in_load  = in_valid && !in_stall;

  lsmt_core #(
    .LINE_CYCLES   (LINE_CYCLES),
    .SCAN_CYCLES   (SCAN_CYCLES),
    .XFER_CYCLES   (XFER_CYCLES),
    .VISIBLE_LINES (VISIBLE_LINES),
    .LAST_LINE     (LAST_LINE)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .req     (in_data_r),
    .res     (res)
  );

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_valid_r || out_adv) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_load) begin
      in_data_r <= in_data;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ test/lcd_scanline_mode_timer_top_tb.sv @@
// testbench for the lcd scanline mode timer: directed ticks, long runs of random ticks, stalls
`timescale 1ns / 100ps

module lcd_scanline_mode_timer_top_tb;
  import lsmt_pkg::*;

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  lsmt_in_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  lsmt_out_t out_data;

  lcd_scanline_mode_timer_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // scanline state as the testbench sees it
  int         cycles_left;
  logic [7:0] scan_line;
  logic [1:0] last_mode;
  logic       line_eq;

  lsmt_out_t expected_timing_q[$];

  int errors      = 0;
  int ticks_sent  = 0;
  int results_ok  = 0;
  int vblank_seen = 0;
  int wraps_seen  = 0;
  int sirq_seen   = 0;
  int idle_pct    = 0;
  int stall_pct   = 0;
  int hold_req    = 0;
  int hold_cnt    = 0;

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // overall time limit
  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

  function automatic void reset_scan_state();
    cycles_left = LINE_CYCLES_DEF;
    scan_line   = '0;
    last_mode   = MODE_HBLANK;
    line_eq     = 1'b0;
  endfunction

  // mode, status request, line match and line advance for one tick
  function automatic lsmt_out_t predict_tick(lsmt_in_t t);
    lsmt_out_t  r;
    logic [1:0] md;
    logic       req;
    logic [8:0] nxt;
    int         scan_b;
    int         xfer_b;
    r = '0;
    req = 1'b0;
    if (!t.lcd_enable) begin
      cycles_left  = LINE_CYCLES_DEF;
      scan_line    = '0;
      last_mode    = MODE_HBLANK;
      r.line_match = line_eq;
      return r;
    end
    // mode from line and countdown
    scan_b = LINE_CYCLES_DEF - SCAN_CYCLES_DEF;
    xfer_b = scan_b - XFER_CYCLES_DEF;
    if (scan_line >= VISIBLE_LINES_DEF) begin
      md  = MODE_VBLANK;
      req = t.vblank_irq_en;
    end else if (cycles_left >= scan_b) begin
      md  = MODE_SCAN;
      req = t.oam_irq_en;
    end else if (cycles_left >= xfer_b) begin
      md  = MODE_XFER;
    end else begin
      md  = MODE_HBLANK;
      req = t.hblank_irq_en;
    end
    if (req && md != last_mode) r.status_irq = 1'b1;
    line_eq = (scan_line == t.compare_line);
    if (line_eq && t.match_irq_en) r.status_irq = 1'b1;
    last_mode = md;
    // countdown and line advance
    cycles_left = cycles_left - int'(t.tick_cycles);
    if (cycles_left <= 0) begin
      nxt = {1'b0, scan_line} + 9'd1;
      cycles_left = LINE_CYCLES_DEF;
      if (nxt == VISIBLE_LINES_DEF) begin
        r.vblank_irq = 1'b1;
      end else if (nxt > LAST_LINE_DEF) begin
        nxt = '0;
        r.frame_wrap = 1'b1;
      end else if (nxt < VISIBLE_LINES_DEF) begin
        r.line_start = 1'b1;
      end
      scan_line = nxt[7:0];
    end
    r.line_now   = scan_line;
    r.mode_now   = md;
    r.line_match = line_eq;
    return r;
  endfunction

  // receiver stall, with an optional long hold-off
  always @(posedge clk) begin
    if (hold_req != 0) begin
      hold_cnt = hold_req;
      hold_req = 0;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // result checker
  always @(posedge clk) begin
    lsmt_out_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_timing_q.size() == 0) begin
        $error("result with no request outstanding: %p", out_data);
        errors++;
      end else begin
        exp_r = expected_timing_q.pop_front();
        if (out_data.line_now !== exp_r.line_now) begin
          $error("line_now: expected %0d, got %0d", exp_r.line_now, out_data.line_now);
          errors++;
        end
        if (out_data.mode_now !== exp_r.mode_now) begin
          $error("mode_now: expected %0d, got %0d", exp_r.mode_now, out_data.mode_now);
          errors++;
        end
        if (out_data.line_match !== exp_r.line_match) begin
          $error("line_match: expected %0b, got %0b", exp_r.line_match, out_data.line_match);
          errors++;
        end
        if (out_data.status_irq !== exp_r.status_irq) begin
          $error("status_irq: expected %0b, got %0b", exp_r.status_irq, out_data.status_irq);
          errors++;
        end
        if (out_data.vblank_irq !== exp_r.vblank_irq) begin
          $error("vblank_irq: expected %0b, got %0b", exp_r.vblank_irq, out_data.vblank_irq);
          errors++;
        end
        if (out_data.line_start !== exp_r.line_start) begin
          $error("line_start: expected %0b, got %0b", exp_r.line_start, out_data.line_start);
          errors++;
        end
        if (out_data.frame_wrap !== exp_r.frame_wrap) begin
          $error("frame_wrap: expected %0b, got %0b", exp_r.frame_wrap, out_data.frame_wrap);
          errors++;
        end
        results_ok++;
        vblank_seen += exp_r.vblank_irq;
        wraps_seen  += exp_r.frame_wrap;
        sirq_seen   += exp_r.status_irq;
      end
    end
  end

  // offer one request, predict it once accepted
  task automatic send_tick(input lsmt_in_t t);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= t;
    do @(posedge clk); while (in_stall);
    expected_timing_q.push_back(predict_tick(t));
    ticks_sent++;
  endtask

  // stop offering and wait for every outstanding result
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_timing_q.size() != 0);
  endtask

  function automatic lsmt_in_t make_tick(input int cyc, input bit en, input bit hb,
                                         input bit vb, input bit oam, input bit me,
                                         input int cmp);
    lsmt_in_t t;
    t.tick_cycles   = cyc[5:0];
    t.lcd_enable    = en;
    t.hblank_irq_en = hb;
    t.vblank_irq_en = vb;
    t.oam_irq_en    = oam;
    t.match_irq_en  = me;
    t.compare_line  = cmp[7:0];
    return t;
  endfunction

  // mostly long ticks with display on, so that many lines go by
  function automatic lsmt_in_t random_tick(input int off_pct);
    lsmt_in_t t;
    t.tick_cycles   = 6'(($urandom_range(0, 99) < 95) ? $urandom_range(56, 63)
                                                      : $urandom_range(0, 63));
    t.lcd_enable    = ($urandom_range(0, 99) >= off_pct);
    t.hblank_irq_en = 1'($urandom_range(0, 1));
    t.vblank_irq_en = 1'($urandom_range(0, 1));
    t.oam_irq_en    = 1'($urandom_range(0, 1));
    t.match_irq_en  = 1'($urandom_range(0, 1));
    t.compare_line  = ($urandom_range(0, 99) < 30) ? scan_line
                                                   : 8'($urandom_range(0, 255));
    return t;
  endfunction

  // display off and on, mode sequence within a line, match flag, first line advance
  task automatic test_directed();
    int k;
    idle_pct  = 0;
    stall_pct = 0;
    send_tick(make_tick(63, 0, 1, 1, 1, 1, 0));
    send_tick(make_tick(0, 1, 0, 0, 1, 1, 0));
    // display off keeps the last match flag
    send_tick(make_tick(0, 0, 0, 0, 0, 0, 255));
    send_tick(make_tick(63, 1, 0, 0, 0, 0, 255));
    // walk through transfer into hblank and on to the next line
    for (k = 0; k < 8; k++) begin
      send_tick(make_tick(63, 1, 1, 1, 1, 0, 153));
    end
    send_tick(make_tick(1, 1, 1, 0, 1, 1, 1));
    send_tick(make_tick(0, 1, 0, 1, 0, 1, 144));
    send_tick(make_tick(32, 1, 1, 1, 1, 1, 1));
    send_tick(make_tick(63, 0, 1, 1, 1, 1, 0));
    wait_drained();
  endtask

  // receiver holds off long enough that the block stalls its input
  task automatic test_backpressure();
    int k;
    idle_pct  = 0;
    stall_pct = 0;
    hold_req  = 40;
    for (k = 0; k < 12; k++) begin
      send_tick(random_tick(0));
    end
    wait_drained();
  endtask

  // sender pauses until everything is back, then resumes
  task automatic test_drain_pause();
    int k;
    idle_pct  = 10;
    stall_pct = 20;
    for (k = 0; k < 6; k++) begin
      send_tick(random_tick(0));
    end
    wait_drained();
    repeat (10) @(posedge clk);
    for (k = 0; k < 6; k++) begin
      send_tick(random_tick(0));
    end
    wait_drained();
  endtask

  // one random phase; display off only allowed late in the phase
  task automatic test_random_phase(input int n, input int idle, input int stall,
                                   input int off_after, input int off_pct);
    int k;
    idle_pct  = idle;
    stall_pct = stall;
    for (k = 0; k < n; k++) begin
      send_tick(random_tick((k >= off_after) ? off_pct : 0));
    end
    wait_drained();
  endtask

  initial begin
    reset_scan_state();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_backpressure();
    test_drain_pause();
    test_random_phase(220, 0, 0, 220, 0);
    test_random_phase(220, 47, 0, 220, 0);
    test_random_phase(220, 0, 47, 220, 0);
    test_random_phase(260, 27, 27, 180, 3);

    repeat (5) @(posedge clk);
    $display("ticks sent %0d, results checked %0d", ticks_sent, results_ok);
    $display("vblank entries %0d, frame wraps %0d, status requests %0d",
             vblank_seen, wraps_seen, sirq_seen);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
